// File: sv/psort_pkg.sv
// Shared constants, key type and key conversion functions for the point pair sorter.
package psort_pkg;

    localparam int COORD_W        = 16;
    localparam int KEY_W          = 2 * COORD_W;
    localparam int MAX_POINTS_DEF = 32;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic signed [COORD_W-1:0] coord_t;

    // Sign bits inverted so that unsigned key order is order by x, then y.
    function automatic key_t make_key(input coord_t x, input coord_t y);
        return {~x[COORD_W-1], x[COORD_W-2:0], ~y[COORD_W-1], y[COORD_W-2:0]};
    endfunction

    function automatic coord_t key_x(input key_t k);
        return {~k[KEY_W-1], k[KEY_W-2:COORD_W]};
    endfunction

    function automatic coord_t key_y(input key_t k);
        return {~k[COORD_W-1], k[COORD_W-2:0]};
    endfunction

endpackage

// File: sv/psort_mem.sv
// Point key store: one write port, one read port, registered read data.
module psort_mem import psort_pkg::*; #(
    parameter int DEPTH = MAX_POINTS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  key_t          wr_data,
    input  logic [AW-1:0] rd_addr,
    output key_t          rd_data
);

    key_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// File: sv/point_pair_sorter.sv
// Point pair sorter: stores points by insertion into a key memory, then streams them out.
// A request on an empty store writes its point directly and one on a full store drops it;
// otherwise the insertion loop moves one entry per cycle through the memory, then places the key.
// After a final request the set streams out through ST_RD, ST_LD and ST_WAIT for each result,
// since the store's read data is registered; the next read waits until m_ready takes the result.
// aresetn (synchronous, active low) empties the store; its contents need no clearing.
module point_pair_sorter import psort_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_point_x,
    input  logic signed [COORD_W-1:0] s_point_y,
    input  logic                      s_final_point,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COORD_W-1:0] m_sorted_x,
    output logic signed [COORD_W-1:0] m_sorted_y,
    output logic                      m_end_of_set
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PLACE,
        ST_RD,
        ST_LD,
        ST_WAIT
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] idx_reg, idx_next;
    key_t          key_reg, key_next;
    logic          final_reg, final_next;
    logic          m_valid_reg, m_valid_next;
    logic          last_reg, last_next;
    coord_t        out_x_reg, out_x_next;
    coord_t        out_y_reg, out_y_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    key_t          wr_data;
    logic [AW-1:0] rd_addr;
    key_t          rd_data;
    logic          s_accept;

    psort_mem #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready      = (state_reg == ST_IDLE);
    assign s_accept     = s_valid && s_ready;
    assign m_valid      = m_valid_reg;
    assign m_sorted_x   = out_x_reg;
    assign m_sorted_y   = out_y_reg;
    assign m_end_of_set = last_reg;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        idx_next     = idx_reg;
        key_next     = key_reg;
        final_next   = final_reg;
        m_valid_next = m_valid_reg;
        last_next    = last_reg;
        out_x_next   = out_x_reg;
        out_y_next   = out_y_reg;
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = key_reg;
        rd_addr      = idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    key_next   = make_key(s_point_x, s_point_y);
                    final_next = s_final_point;
                    if (count_reg == CW'(MAX_POINTS)) begin
                        // store full: point dropped
                        if (s_final_point) begin
                            idx_next   = '0;
                            state_next = ST_RD;
                        end
                    end else if (count_reg == '0) begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = make_key(s_point_x, s_point_y);
                        count_next = CW'(1);
                        if (s_final_point) begin
                            idx_next   = '0;
                            state_next = ST_RD;
                        end
                    end else begin
                        rd_addr    = count_reg[AW-1:0] - AW'(1);
                        pos_next   = count_reg[AW-1:0];
                        state_next = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: begin
                wr_en = 1'b1;
                if (rd_data > key_reg) begin
                    wr_addr  = pos_reg;
                    wr_data  = rd_data;
                    pos_next = pos_reg - AW'(1);
                    if (pos_reg == AW'(1)) begin
                        state_next = ST_PLACE;
                    end else begin
                        rd_addr = pos_reg - AW'(2);
                    end
                end else begin
                    wr_addr    = pos_reg;
                    wr_data    = key_reg;
                    count_next = count_reg + CW'(1);
                    idx_next   = '0;
                    state_next = final_reg ? ST_RD : ST_IDLE;
                end
            end
            ST_PLACE: begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = key_reg;
                count_next = count_reg + CW'(1);
                idx_next   = '0;
                state_next = final_reg ? ST_RD : ST_IDLE;
            end
            ST_RD: begin
                rd_addr    = idx_reg;
                state_next = ST_LD;
            end
            ST_LD: begin
                out_x_next   = key_x(rd_data);
                out_y_next   = key_y(rd_data);
                m_valid_next = 1'b1;
                last_next    = (CW'(idx_reg) == count_reg - CW'(1));
                state_next   = ST_WAIT;
            end
            ST_WAIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (last_reg) begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        pos_reg   <= pos_next;
        idx_reg   <= idx_next;
        key_reg   <= key_next;
        final_reg <= final_next;
        last_reg  <= last_next;
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while a result is pending");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_set_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_end_of_set) |=> (count_reg == '0) && s_ready)
        else $error("store not emptied after last result");

    a_shift_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT) |-> (pos_reg != '0) && (CW'(pos_reg) == count_reg ||
            CW'(pos_reg) < count_reg))
        else $error("insertion position out of range");

endmodule

// File: dv/point_pair_sorter_tb.sv
// Self-checking testbench for point_pair_sorter: directed and random point sets against a predictor.
module point_pair_sorter_tb;
    import psort_pkg::*;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last;
    } sorted_pt_t;

    typedef struct {
        int   x;
        int   y;
        logic fin;
        logic typed;
        int   ex;
        int   ey;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 24;
    localparam int RANDOM_POINTS = 500;
    localparam int HOLD_CYCLES   = 400;

    logic   aclk;
    logic   aresetn;
    logic   s_valid;
    logic   s_ready;
    coord_t s_point_x;
    coord_t s_point_y;
    logic   s_final_point;
    logic   m_valid;
    logic   m_ready;
    coord_t m_sorted_x;
    coord_t m_sorted_y;
    logic   m_end_of_set;

    logic [KEY_W-1:0] held_keys [MAX_POINTS_DEF];
    int               held_count;
    sorted_pt_t       due_points [$];

    int errors;
    int points_in;
    int sets_in;
    int overflow_sets;
    int results_seen;
    int input_stall_cycles;
    int burst_left;
    bit held_off;

    stim_row_t directed [DIRECTED_ROWS] = '{
        '{-32768,  32767, 1'b1, 1'b1, -32768,  32767},
        '{ 32767, -32768, 1'b1, 1'b1,  32767, -32768},
        '{     0,      0, 1'b1, 1'b1,      0,      0},
        '{    -1,     -1, 1'b1, 1'b1,     -1,     -1},
        '{ 32767,  32767, 1'b1, 1'b1,  32767,  32767},
        // ties in x, duplicate point
        '{     5,      3, 1'b0, 1'b0, 0, 0},
        '{     5,     -3, 1'b0, 1'b0, 0, 0},
        '{    -5,      7, 1'b0, 1'b0, 0, 0},
        '{     5,      3, 1'b0, 1'b0, 0, 0},
        '{    -5,     -7, 1'b0, 1'b0, 0, 0},
        '{     0,      0, 1'b1, 1'b0, 0, 0},
        // signed ordering around zero and the extremes
        '{ 32767,      0, 1'b0, 1'b0, 0, 0},
        '{-32768,      0, 1'b0, 1'b0, 0, 0},
        '{     0, -32768, 1'b0, 1'b0, 0, 0},
        '{     0,  32767, 1'b0, 1'b0, 0, 0},
        '{    -1,      1, 1'b0, 1'b0, 0, 0},
        '{     1,     -1, 1'b0, 1'b0, 0, 0},
        '{-32768, -32768, 1'b1, 1'b0, 0, 0},
        // descending input
        '{     3,      0, 1'b0, 1'b0, 0, 0},
        '{     2,      0, 1'b0, 1'b0, 0, 0},
        '{     1,      0, 1'b0, 1'b0, 0, 0},
        '{     0,      0, 1'b1, 1'b0, 0, 0},
        // identical pair
        '{   100,   -100, 1'b0, 1'b0, 0, 0},
        '{   100,   -100, 1'b1, 1'b0, 0, 0}
    };

    point_pair_sorter dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_point_x     (s_point_x),
        .s_point_y     (s_point_y),
        .s_final_point (s_final_point),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sorted_x    (m_sorted_x),
        .m_sorted_y    (m_sorted_y),
        .m_end_of_set  (m_end_of_set)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [KEY_W-1:0] order_key(input coord_t x, input coord_t y);
        return {x ^ 16'h8000, y ^ 16'h8000};
    endfunction

    // Predictor: keep keys up to capacity; on the final request sort them and queue the points.
    task automatic record_point(input coord_t x, input coord_t y, input logic fin,
                                input logic typed, input coord_t ex, input coord_t ey);
        logic [KEY_W-1:0] k;
        sorted_pt_t       pt;
        int               i;
        int               j;
        if (held_count < MAX_POINTS_DEF) begin
            held_keys[held_count] = order_key(x, y);
            held_count++;
        end
        if (fin) begin
            for (i = 1; i < held_count; i++) begin
                k = held_keys[i];
                j = i;
                while (j > 0 && held_keys[j-1] > k) begin
                    held_keys[j] = held_keys[j-1];
                    j--;
                end
                held_keys[j] = k;
            end
            if (typed) begin
                pt.x    = ex;
                pt.y    = ey;
                pt.last = 1'b1;
                due_points.push_back(pt);
            end else begin
                for (i = 0; i < held_count; i++) begin
                    pt.x    = held_keys[i][KEY_W-1:COORD_W] ^ 16'h8000;
                    pt.y    = held_keys[i][COORD_W-1:0] ^ 16'h8000;
                    pt.last = (i == held_count - 1);
                    due_points.push_back(pt);
                end
            end
            held_count = 0;
            sets_in++;
        end
    endtask

    // Called at a falling edge; returns at a falling edge.
    task automatic offer_point(input coord_t x, input coord_t y, input logic fin,
                               input logic typed, input coord_t ex, input coord_t ey);
        int gap;
        s_valid       <= 1'b1;
        s_point_x     <= x;
        s_point_y     <= y;
        s_final_point <= fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        points_in++;
        record_point(x, y, fin, typed, ex, ey);
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 10);
            gap        = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(1, 5);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    function automatic coord_t pick_coord();
        case ($urandom_range(0, 5))
            0: return coord_t'(int'($urandom_range(0, 6)) - 3);
            1: begin
                case ($urandom_range(0, 3))
                    0: return 16'sh8000;
                    1: return 16'sh7fff;
                    2: return -16'sd1;
                    default: return 16'sd0;
                endcase
            end
            default: return coord_t'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic offer_set(input int n);
        int i;
        if (n > MAX_POINTS_DEF) overflow_sets++;
        for (i = 0; i < n; i++) begin
            offer_point(pick_coord(), pick_coord(), i == n - 1, 1'b0, 16'sd0, 16'sd0);
        end
    endtask

    function automatic int pick_set_size();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 5) return $urandom_range(1, 6);
        if (r <= 7) return $urandom_range(7, 20);
        if (r == 8) return $urandom_range(28, MAX_POINTS_DEF);
        return $urandom_range(MAX_POINTS_DEF + 1, MAX_POINTS_DEF + 8);
    endfunction

    initial begin
        int start;
        int r;
        s_valid       = 1'b0;
        s_point_x     = '0;
        s_point_y     = '0;
        s_final_point = 1'b0;
        aresetn       = 1'b0;
        held_count    = 0;
        burst_left    = 0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        for (r = 0; r < DIRECTED_ROWS; r++) begin
            offer_point(coord_t'(directed[r].x), coord_t'(directed[r].y), directed[r].fin,
                        directed[r].typed, coord_t'(directed[r].ex),
                        coord_t'(directed[r].ey));
        end

        start = points_in;
        offer_set(MAX_POINTS_DEF + 8);
        while (points_in - start < RANDOM_POINTS) offer_set(pick_set_size());

        @(negedge aclk);
        s_valid <= 1'b0;
        while (due_points.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("%0d points in %0d sets (%0d over capacity), %0d sorted points checked",
                 points_in, sets_in, overflow_sets, results_seen);
        $display("input back-pressured for %0d cycles", input_stall_cycles);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Receiver: random stall modes, plus one long hold-off that back-pressures the output.
    initial begin
        int mode;
        int span;
        m_ready  = 1'b0;
        held_off = 1'b0;
        @(posedge aresetn);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
            repeat (span) begin
                @(negedge aclk);
                if (!held_off && points_in >= DIRECTED_ROWS + 100) begin
                    held_off = 1'b1;
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge aclk);
                end
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 1) == 1);
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        sorted_pt_t want;
        if (aresetn && s_valid && !s_ready) input_stall_cycles++;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (due_points.size() == 0) begin
                errors++;
                $display("%0t: unexpected result x=%0d y=%0d end=%0b",
                         $time, m_sorted_x, m_sorted_y, m_end_of_set);
            end else begin
                want = due_points.pop_front();
                if (m_sorted_x !== want.x) begin
                    errors++;
                    $display("%0t: sorted_x expected %0d, got %0d", $time, want.x, m_sorted_x);
                end
                if (m_sorted_y !== want.y) begin
                    errors++;
                    $display("%0t: sorted_y expected %0d, got %0d", $time, want.y, m_sorted_y);
                end
                if (m_end_of_set !== want.last) begin
                    errors++;
                    $display("%0t: end_of_set expected %0b, got %0b",
                             $time, want.last, m_end_of_set);
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
